// ===== rtl/eida_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eida_pkg: shared types and constants of the entity ID allocator
// Operation and status codes, beat structs and default sizes.
// ----------------------------------------------------------------------------
package eida_pkg;

  localparam int ENTRIES_DEF        = 256;
  localparam int COMPONENT_BITS_DEF = 16;

  localparam int OP_W     = 3;
  localparam int ID_FLD_W = 8;
  localparam int MASK_W   = 16;
  localparam int STATUS_W = 2;
  localparam int COUNT_W  = 9;

  typedef enum logic [OP_W-1:0] {
    OP_CREATE  = 3'd0,
    OP_DESTROY = 3'd1,
    OP_HAS     = 3'd2,
    OP_ADD     = 3'd3,
    OP_REMOVE  = 3'd4,
    OP_CLEAR   = 3'd5
  } op_t;

  typedef enum logic [STATUS_W-1:0] {
    ST_DONE     = 2'd0,
    ST_FULL     = 2'd1,
    ST_NOT_LIVE = 2'd2
  } status_t;

  typedef struct packed {
    op_t                 op;
    logic [ID_FLD_W-1:0] entity_id;
    logic [MASK_W-1:0]   sel_mask;
  } cmd_t;

  typedef struct packed {
    status_t             status;
    logic [ID_FLD_W-1:0] new_id;
    logic                answer;
    logic [COUNT_W-1:0]  live_count;
  } res_t;

  typedef struct packed {
    logic                pop;
    logic                push;
    logic                restore;
    logic [ID_FLD_W-1:0] push_id;
  } fl_ctrl_t;

endpackage
`default_nettype wire

// ===== rtl/eida_free_list.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// eida_free_list: stack of free entity IDs
// A pop reads the stack memory and presents the popped ID in the next cycle.
// Positions below the low-water mark still hold their restore value, so a
// restore needs no pass over the memory.
// ----------------------------------------------------------------------------
module eida_free_list
  import eida_pkg::*;
#(
  parameter int ENTRIES = ENTRIES_DEF
) (
  input  logic                             clk,
  input  logic                             rst,
  input  fl_ctrl_t                         ctl,
  output logic [$clog2(ENTRIES+1)-1:0]     depth,
  output logic [$clog2(ENTRIES)-1:0]       nid
);

  localparam int ID_W    = $clog2(ENTRIES);
  localparam int DEPTH_W = $clog2(ENTRIES+1);

  logic [DEPTH_W-1:0] low_mark;
  logic [DEPTH_W-1:0] top_pos;
  logic [ID_W-1:0]    stack [ENTRIES];
  logic [ID_W-1:0]    stk_q;
  logic [ID_W-1:0]    pos_q;
  logic               use_init_q;
  logic               full;

  assign top_pos = depth - DEPTH_W'(1);
  assign full    = (depth == DEPTH_W'(ENTRIES));

  always_ff @(posedge clk) begin
    if (rst) begin
      depth    <= DEPTH_W'(ENTRIES);
      low_mark <= DEPTH_W'(ENTRIES);
    end else if (ctl.restore) begin
      depth    <= DEPTH_W'(ENTRIES);
      low_mark <= DEPTH_W'(ENTRIES);
    end else if (ctl.pop) begin
      depth <= top_pos;
      if (top_pos < low_mark) begin
        low_mark <= top_pos;
      end
    end else if (ctl.push && !full) begin
      depth <= depth + DEPTH_W'(1);
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.pop) begin
      stk_q      <= stack[ID_W'(top_pos)];
      pos_q      <= ID_W'(top_pos);
      use_init_q <= (top_pos < low_mark);
    end
    if (ctl.push && !full) begin
      stack[ID_W'(depth)] <= ID_W'(ctl.push_id);
    end
  end

  assign nid = use_init_q ? (ID_W'(ENTRIES - 1) - pos_q) : stk_q;

`ifndef SYNTHESIS
  a_depth_bound: assert property (@(posedge clk) disable iff (rst)
    depth <= DEPTH_W'(ENTRIES))
    else $error("free list depth above entry count");
  a_mark_bound: assert property (@(posedge clk) disable iff (rst)
    low_mark <= depth)
    else $error("low-water mark above depth");
  a_pop_empty: assert property (@(posedge clk) disable iff (rst)
    ctl.pop |-> depth != '0)
    else $error("pop from empty free list");
`endif

endmodule
`default_nettype wire

// ===== rtl/entity_id_allocator_unit.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// entity_id_allocator_unit: entity ID allocator with component masks
// Hands out IDs from a free list and keeps a live flag and a component
// mask for each entry.
// ----------------------------------------------------------------------------
// Usage:
//   The cmd channel takes one command beat (op, entity_id, sel_mask) per
//   cycle while cmd_stall is low; every command yields exactly one res beat
//   (status, new_id, answer, live_count), in order.
//   A beat accepted on cmd passes the internal stage and the result
//   register before it shows on res. It takes one beat per cycle while
//   nothing stalls, set by the single read ports of the stack and the
//   component memory, each read at most once per command into a register.
//   Reset returns the free list to full with ID 0 on top and clears all
//   live flags. The clear command does the same.
//   Component masks are zeroed when an ID is created, not at reset.
//   When the receiver stalls, the result register holds its beat, one more
//   command can sit in the internal stage, and then cmd_stall rises.
// ----------------------------------------------------------------------------
module entity_id_allocator_unit
  import eida_pkg::*;
#(
  parameter int ENTRIES        = ENTRIES_DEF,
  parameter int COMPONENT_BITS = COMPONENT_BITS_DEF
) (
  input  logic clk,
  input  logic rst,
  input  logic cmd_valid,
  output logic cmd_stall,
  input  cmd_t cmd,
  output logic res_valid,
  input  logic res_stall,
  output res_t res
);

  localparam int ID_W    = $clog2(ENTRIES);
  localparam int DEPTH_W = $clog2(ENTRIES+1);
  localparam int CB      = COMPONENT_BITS;

  logic               acc;
  logic               b_adv;
  logic               b_valid;
  op_t                b_op;
  status_t            b_status;
  logic [ID_W-1:0]    b_idx;
  logic [MASK_W-1:0]  b_mask;
  logic               b_live;
  logic               b_create_ok;

  fl_ctrl_t           fl_ctl;
  logic [DEPTH_W-1:0] fl_depth;
  logic [ID_W-1:0]    fl_nid;

  logic [ENTRIES-1:0] live;
  logic [CB-1:0]      comp_mem [ENTRIES];
  logic [CB-1:0]      comp_q;
  logic               comp_we;
  logic [ID_W-1:0]    comp_waddr;
  logic [CB-1:0]      comp_wdata;

  logic [ID_W-1:0]    a_idx;
  logic               a_in_range;
  logic               a_live;
  logic               a_full;
  status_t            a_status;
  res_t               res_next;

  assign b_adv     = b_valid && (!res_valid || !res_stall);
  assign cmd_stall = b_valid && !b_adv;
  assign acc       = cmd_valid && !cmd_stall;

  always_comb begin
    a_idx      = ID_W'(cmd.entity_id);
    a_in_range = (32'(cmd.entity_id) < ENTRIES);
    a_live     = a_in_range &&
                 (live[a_idx] || (b_adv && b_create_ok && (fl_nid == a_idx)));
    a_full     = (fl_depth == '0);
    unique case (cmd.op)
      OP_CREATE:                               a_status = a_full ? ST_FULL : ST_DONE;
      OP_DESTROY, OP_HAS, OP_ADD, OP_REMOVE:   a_status = a_live ? ST_DONE : ST_NOT_LIVE;
      default:                                 a_status = ST_DONE;
    endcase
    fl_ctl.pop     = acc && (cmd.op == OP_CREATE) && !a_full;
    fl_ctl.push    = acc && (cmd.op == OP_DESTROY) && a_live;
    fl_ctl.restore = acc && (cmd.op == OP_CLEAR);
    fl_ctl.push_id = cmd.entity_id;
  end

  eida_free_list #(
    .ENTRIES (ENTRIES)
  ) u_free_list (
    .clk   (clk),
    .rst   (rst),
    .ctl   (fl_ctl),
    .depth (fl_depth),
    .nid   (fl_nid)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (acc) begin
      b_valid <= 1'b1;
    end else if (b_adv) begin
      b_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (acc) begin
      b_op        <= cmd.op;
      b_status    <= a_status;
      b_idx       <= a_idx;
      b_mask      <= cmd.sel_mask;
      b_live      <= a_live;
      b_create_ok <= (cmd.op == OP_CREATE) && !a_full;
    end
  end

  // The entry written by the stage ahead is passed straight to the read.
  always_ff @(posedge clk) begin
    if (comp_we) begin
      comp_mem[comp_waddr] <= comp_wdata;
    end
    if (acc) begin
      comp_q <= (comp_we && (comp_waddr == a_idx)) ? comp_wdata : comp_mem[a_idx];
    end
  end

  always_comb begin
    comp_we             = 1'b0;
    comp_waddr          = b_idx;
    comp_wdata          = '0;
    res_next.status     = b_status;
    res_next.new_id     = '0;
    res_next.answer     = 1'b0;
    res_next.live_count = COUNT_W'(DEPTH_W'(ENTRIES) - fl_depth);
    unique case (b_op)
      OP_CREATE: begin
        if (b_create_ok) begin
          comp_we         = b_adv;
          comp_waddr      = fl_nid;
          res_next.new_id = ID_FLD_W'(fl_nid);
        end
      end
      OP_HAS: begin
        res_next.answer = b_live && ((MASK_W'(comp_q) & b_mask) == b_mask);
      end
      OP_ADD: begin
        comp_we    = b_adv && b_live;
        comp_wdata = comp_q | CB'(b_mask);
      end
      OP_REMOVE: begin
        comp_we    = b_adv && b_live;
        comp_wdata = comp_q & ~CB'(b_mask);
      end
      default: begin
      end
    endcase
  end

  // A later clear or destroy in the same cycle overrides the create.
  always_ff @(posedge clk) begin
    if (rst) begin
      live <= '0;
    end else begin
      if (b_adv && b_create_ok) begin
        live[fl_nid] <= 1'b1;
      end
      if (fl_ctl.restore) begin
        live <= '0;
      end else if (fl_ctl.push) begin
        live[a_idx] <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      res_valid <= 1'b0;
    end else if (b_adv) begin
      res_valid <= 1'b1;
    end else if (!res_stall) begin
      res_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (b_adv) begin
      res <= res_next;
    end
  end

`ifndef SYNTHESIS
  a_create_fresh: assert property (@(posedge clk) disable iff (rst)
    b_adv && b_create_ok |-> !live[fl_nid])
    else $error("created ID was already live");
  a_stall_cause: assert property (@(posedge clk) disable iff (rst)
    cmd_stall |-> res_valid && res_stall && b_valid)
    else $error("command stalled without a stalled result");
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !res_valid && !b_valid)
    else $error("beat present after reset");
  a_destroy_live: assert property (@(posedge clk) disable iff (rst)
    fl_ctl.push |=> !live[$past(a_idx)] || $past(b_adv && b_create_ok))
    else $error("destroyed entry still live");
`endif

endmodule
`default_nettype wire
